### rtl/msq_pkg.sv
// ============================================================================
// msq_pkg - shared types and constants for the subscriber event queues
// Holds sizes, command and result words, opcodes and the ring helpers.
// ============================================================================
package msq_pkg;

	// Sizing
	localparam int NUM_QUEUES  = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int STAMP_BITS  = 32;

	localparam int QIX_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOT_W  = $clog2(NUM_QUEUES * QUEUE_DEPTH);
	localparam int SLOTS   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int REC_W   = STAMP_BITS + 1;

	// Command queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// Port field widths (fixed by the item format)
	localparam int KIND_W      = 3;
	localparam int QID_W       = 2;
	localparam int IN_STAMP_W  = 32;
	localparam int STATUS_W    = 2;
	localparam int IN_FIELDS_W = QID_W + IN_STAMP_W + 2;
	localparam int IN_DATA_W   = 8 * ((IN_FIELDS_W + 7) / 8);
	localparam int OUT_FIELDS_W = QID_W + IN_STAMP_W + 1;
	localparam int OUT_DATA_W  = 8 * ((OUT_FIELDS_W + 7) / 8);

	// Item kinds on the input stream
	localparam logic [KIND_W-1:0] KIND_EDGE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd2;

	typedef enum logic [2:0] {
		OP_EDGE,
		OP_WRITE,
		OP_READ,
		OP_OPEN,
		OP_CLOSE,
		OP_FLUSH,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDGE,
		ST_READ
	} state_t;

	typedef struct packed {
		op_t                   op;
		logic [QIX_W-1:0]      qid;
		logic [STAMP_BITS-1:0] stamp;
		logic                  flag;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [QID_W-1:0]      granted_queue;
		logic [IN_STAMP_W-1:0] out_stamp;
		logic                  out_flag;
	} res_t;

	// Fit the port time stamp to the stored width
	function automatic logic [STAMP_BITS-1:0] to_store_stamp(input logic [IN_STAMP_W-1:0] s);
		logic [63:0] w;
		w = 64'(s);
		return w[STAMP_BITS-1:0];
	endfunction

	// Fit a stored time stamp to the port width
	function automatic logic [IN_STAMP_W-1:0] to_port_stamp(input logic [STAMP_BITS-1:0] s);
		logic [63:0] w;
		w = 64'(s);
		return w[IN_STAMP_W-1:0];
	endfunction

	function automatic logic [QIX_W-1:0] to_qix(input logic [QID_W-1:0] q);
		logic [31:0] w;
		w = 32'(q);
		return w[QIX_W-1:0];
	endfunction

	// Advance a ring position by one
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Ring position of head plus count; the sum stays below twice the depth
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] c);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(p) + (CNT_W+1)'(c);
		if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	// Record store address of one ring position of one queue
	function automatic logic [SLOT_W-1:0] slot_of(input logic [QIX_W-1:0] q,
		input logic [PTR_W-1:0] p);
		return SLOT_W'(q) * SLOT_W'(QUEUE_DEPTH) + SLOT_W'(p);
	endfunction

endpackage

### rtl/msq_front.sv
// ============================================================================
// msq_front - input side of the subscriber event queues
// Accepts items, decodes them into commands and buffers them for the back.
// ============================================================================
module msq_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [msq_pkg::KIND_W-1:0]        kind,
	input  logic [msq_pkg::QID_W-1:0]         queue_id,
	input  logic [msq_pkg::IN_STAMP_W-1:0]    time_stamp,
	input  logic                              pin_level,
	input  logic                              record_flag,
	output logic                              cmd_valid,
	input  logic                              cmd_ready,
	output msq_pkg::cmd_t                     cmd
);

	msq_pkg::cmd_t                 dec_cmd;
	logic                          q_ok;
	msq_pkg::cmd_t                 fifo_q [msq_pkg::FIFO_DEPTH];
	logic [msq_pkg::FPTR_W-1:0]    wptr_q;
	logic [msq_pkg::FPTR_W-1:0]    rptr_q;
	logic [msq_pkg::FCNT_W-1:0]    fcnt_q;
	logic                          wr_en;
	logic                          rd_en;

	assign q_ok = 32'(queue_id) < 32'(msq_pkg::NUM_QUEUES);

	// Classify: targeted kinds aimed past the last queue become no-ops
	always_comb begin
		dec_cmd.qid   = msq_pkg::to_qix(queue_id);
		dec_cmd.stamp = msq_pkg::to_store_stamp(time_stamp);
		dec_cmd.flag  = record_flag;
		case (kind)
			msq_pkg::KIND_EDGE: begin
				dec_cmd.op   = msq_pkg::OP_EDGE;
				dec_cmd.flag = ~pin_level;
			end
			msq_pkg::KIND_WRITE: dec_cmd.op = q_ok ? msq_pkg::OP_WRITE : msq_pkg::OP_NOP;
			msq_pkg::KIND_READ:  dec_cmd.op = q_ok ? msq_pkg::OP_READ  : msq_pkg::OP_NOP;
			msq_pkg::KIND_OPEN:  dec_cmd.op = msq_pkg::OP_OPEN;
			msq_pkg::KIND_CLOSE: dec_cmd.op = q_ok ? msq_pkg::OP_CLOSE : msq_pkg::OP_NOP;
			msq_pkg::KIND_FLUSH: dec_cmd.op = q_ok ? msq_pkg::OP_FLUSH : msq_pkg::OP_NOP;
			default:             dec_cmd.op = msq_pkg::OP_NOP;
		endcase
	end

	assign in_ready  = fcnt_q != msq_pkg::FCNT_W'(msq_pkg::FIFO_DEPTH);
	assign cmd_valid = fcnt_q != '0;
	assign cmd       = fifo_q[rptr_q];
	assign wr_en     = in_valid & in_ready;
	assign rd_en     = cmd_valid & cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == msq_pkg::FPTR_W'(msq_pkg::FIFO_DEPTH - 1)) ? '0
					: wptr_q + msq_pkg::FPTR_W'(1);
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == msq_pkg::FPTR_W'(msq_pkg::FIFO_DEPTH - 1)) ? '0
					: rptr_q + msq_pkg::FPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				fcnt_q <= fcnt_q + msq_pkg::FCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				fcnt_q <= fcnt_q - msq_pkg::FCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wptr_q] <= dec_cmd;
		end
	end

endmodule

### rtl/msq_back.sv
// ============================================================================
// msq_back - execution side of the subscriber event queues
// Holds queue state and the record store, runs commands, registers results.
// ============================================================================
module msq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  msq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output msq_pkg::res_t res
);

	localparam int NQ = msq_pkg::NUM_QUEUES;

	msq_pkg::state_t              state_q;
	msq_pkg::state_t              state_d;

	logic                         open_q  [NQ];
	logic                         open_d  [NQ];
	logic [msq_pkg::CNT_W-1:0]    count_q [NQ];
	logic [msq_pkg::CNT_W-1:0]    count_d [NQ];
	logic [msq_pkg::PTR_W-1:0]    head_q  [NQ];
	logic [msq_pkg::PTR_W-1:0]    head_d  [NQ];

	logic [msq_pkg::QIX_W-1:0]    idx_q;
	logic [msq_pkg::STAMP_BITS-1:0] edge_stamp_q;
	logic                         edge_flag_q;

	logic                         slot_free;
	logic                         take;
	logic [msq_pkg::QIX_W-1:0]    sel_q;
	logic [msq_pkg::CNT_W-1:0]    sel_cnt;
	logic [msq_pkg::PTR_W-1:0]    sel_head;
	logic                         sel_full;
	logic                         sel_empty;
	logic [msq_pkg::PTR_W-1:0]    push_ptr;
	logic                         last_idx;

	logic                         free_hit;
	logic [msq_pkg::QIX_W-1:0]    free_idx;

	logic                         res_valid_q;
	msq_pkg::res_t                res_q;
	logic                         res_load;
	msq_pkg::res_t                res_d;

	logic [msq_pkg::REC_W-1:0]    store_mem [msq_pkg::SLOTS];
	logic                         mem_we;
	logic [msq_pkg::SLOT_W-1:0]   mem_waddr;
	logic [msq_pkg::REC_W-1:0]    mem_wdata;
	logic                         mem_re;
	logic [msq_pkg::SLOT_W-1:0]   mem_raddr;
	logic [msq_pkg::REC_W-1:0]    mem_rdata_q;

	assign slot_free = !res_valid_q || res_ready;
	assign take      = (state_q == msq_pkg::ST_IDLE) && cmd_valid && slot_free;
	assign cmd_ready = (state_q == msq_pkg::ST_IDLE) && slot_free;

	// Per-queue accesses go through one selected queue, except that open claims the lowest closed queue
	assign sel_q     = (state_q == msq_pkg::ST_EDGE) ? idx_q : cmd.qid;
	assign sel_cnt   = count_q[sel_q];
	assign sel_head  = head_q[sel_q];
	assign sel_full  = sel_cnt == msq_pkg::CNT_W'(msq_pkg::QUEUE_DEPTH);
	assign sel_empty = sel_cnt == '0;
	// A full ring overwrites its oldest entry
	assign push_ptr  = sel_full ? sel_head : msq_pkg::ptr_add(sel_head, sel_cnt);
	assign last_idx  = idx_q == msq_pkg::QIX_W'(NQ - 1);

	// Lowest closed queue
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = NQ - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				free_hit = 1'b1;
				free_idx = msq_pkg::QIX_W'(i);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			msq_pkg::ST_IDLE: begin
				if (take) begin
					if (cmd.op == msq_pkg::OP_EDGE) begin
						state_d = msq_pkg::ST_EDGE;
					end else if (cmd.op == msq_pkg::OP_READ && !sel_empty) begin
						state_d = msq_pkg::ST_READ;
					end
				end
			end
			msq_pkg::ST_EDGE: begin
				if (last_idx) begin
					state_d = msq_pkg::ST_IDLE;
				end
			end
			msq_pkg::ST_READ: state_d = msq_pkg::ST_IDLE;
			default:          state_d = msq_pkg::ST_IDLE;
		endcase
	end

	// Datapath and queue state updates
	always_comb begin
		for (int i = 0; i < NQ; i++) begin
			open_d[i]  = open_q[i];
			count_d[i] = count_q[i];
			head_d[i]  = head_q[i];
		end
		mem_we    = 1'b0;
		mem_waddr = msq_pkg::slot_of(sel_q, push_ptr);
		mem_wdata = {cmd.stamp, cmd.flag};
		mem_re    = 1'b0;
		mem_raddr = msq_pkg::slot_of(sel_q, sel_head);
		res_load  = 1'b0;
		res_d     = '0;
		case (state_q)
			msq_pkg::ST_IDLE: begin
				if (take) begin
					case (cmd.op)
						msq_pkg::OP_WRITE: begin
							mem_we         = 1'b1;
							head_d[sel_q]  = sel_full ? msq_pkg::ptr_inc(sel_head) : sel_head;
							count_d[sel_q] = sel_full ? sel_cnt : sel_cnt + msq_pkg::CNT_W'(1);
							res_load       = 1'b1;
						end
						msq_pkg::OP_READ: begin
							if (sel_empty) begin
								res_load     = 1'b1;
								res_d.status = msq_pkg::STATUS_EMPTY;
							end else begin
								mem_re         = 1'b1;
								head_d[sel_q]  = msq_pkg::ptr_inc(sel_head);
								count_d[sel_q] = sel_cnt - msq_pkg::CNT_W'(1);
							end
						end
						msq_pkg::OP_OPEN: begin
							res_load = 1'b1;
							if (free_hit) begin
								open_d[free_idx]    = 1'b1;
								count_d[free_idx]   = '0;
								head_d[free_idx]    = '0;
								res_d.granted_queue = 2'(free_idx);
							end else begin
								res_d.status = msq_pkg::STATUS_NO_FREE;
							end
						end
						msq_pkg::OP_CLOSE: begin
							open_d[sel_q]  = 1'b0;
							count_d[sel_q] = '0;
							res_load       = 1'b1;
						end
						msq_pkg::OP_FLUSH: begin
							count_d[sel_q] = '0;
							res_load       = 1'b1;
						end
						msq_pkg::OP_EDGE: ;
						default: res_load = 1'b1;
					endcase
				end
			end
			msq_pkg::ST_EDGE: begin
				mem_wdata = {edge_stamp_q, edge_flag_q};
				if (open_q[sel_q]) begin
					mem_we         = 1'b1;
					head_d[sel_q]  = sel_full ? msq_pkg::ptr_inc(sel_head) : sel_head;
					count_d[sel_q] = sel_full ? sel_cnt : sel_cnt + msq_pkg::CNT_W'(1);
				end
				res_load = last_idx;
			end
			msq_pkg::ST_READ: begin
				res_load        = 1'b1;
				res_d.out_stamp = msq_pkg::to_port_stamp(mem_rdata_q[msq_pkg::REC_W-1:1]);
				res_d.out_flag  = mem_rdata_q[0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msq_pkg::ST_IDLE;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NQ; i++) begin
				open_q[i]  <= 1'b0;
				count_q[i] <= '0;
				head_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			for (int i = 0; i < NQ; i++) begin
				open_q[i]  <= open_d[i];
				count_q[i] <= count_d[i];
				head_q[i]  <= head_d[i];
			end
			if (take) begin
				idx_q <= '0;
			end else if (state_q == msq_pkg::ST_EDGE) begin
				idx_q <= idx_q + msq_pkg::QIX_W'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			edge_stamp_q <= cmd.stamp;
			edge_flag_q  <= cmd.flag;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// Record store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= store_mem[mem_raddr];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/multi_subscriber_event_queues_core.sv
// ============================================================================
// multi_subscriber_event_queues_core - subscriber queues of motion records
// Four ring queues of sixteen time-stamped records behind a stream interface.
// ============================================================================
// One input word carries one command and gives back exactly one result word,
// in order. tuser selects the command: sensor edge (append the time stamp and
// the inverted pin level to every open queue), write (append one record to
// one queue), read (pop the oldest record of one queue, or report empty),
// open (claim the lowest closed queue, or report none free), close (free a
// queue and empty it) and flush (empty a queue). Appending to a full queue
// drops its oldest record first. A queue id past the last queue, and an
// unused kind, leave everything as is and answer with status ok. Timing: a
// two-entry command queue sits behind s_tready, so input words are taken
// while the execution side is busy or a result waits on m_tready. Write,
// open, close, flush, an empty read and an ignored command run in the idle
// state alone; a read that pops also passes through the read state, as the
// record store read port is registered; a sensor edge steps through the edge
// state, since the single write port of the record store serves the queues
// one after the other. No clearing pass is run after reset: records are read
// only after they were written, and queue state resets in flip-flops at once.
// ============================================================================
module multi_subscriber_event_queues_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] queue_id, [33:2] time_stamp, [34] pin_level, [35] record_flag
	input  logic [msq_pkg::IN_DATA_W-1:0]     s_tdata,
	// [2:0] kind
	input  logic [msq_pkg::KIND_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] granted_queue, [33:2] out_stamp, [34] out_flag
	output logic [msq_pkg::OUT_DATA_W-1:0]    m_tdata,
	// [1:0] status
	output logic [msq_pkg::STATUS_W-1:0]      m_tuser
);

	localparam int QID_LO   = 0;
	localparam int STAMP_LO = QID_LO + msq_pkg::QID_W;
	localparam int PIN_BIT  = STAMP_LO + msq_pkg::IN_STAMP_W;
	localparam int FLAG_BIT = PIN_BIT + 1;

	logic          cmd_valid;
	logic          cmd_ready;
	msq_pkg::cmd_t cmd;
	msq_pkg::res_t res;

	// Front: classify and buffer commands
	msq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.kind        (s_tuser),
		.queue_id    (s_tdata[QID_LO +: msq_pkg::QID_W]),
		.time_stamp  (s_tdata[STAMP_LO +: msq_pkg::IN_STAMP_W]),
		.pin_level   (s_tdata[PIN_BIT]),
		.record_flag (s_tdata[FLAG_BIT]),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd)
	);

	// Back: run commands against queue state and the record store
	msq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result word, zero padded to whole bytes
	assign m_tdata = msq_pkg::OUT_DATA_W'({res.out_flag, res.out_stamp, res.granted_queue});
	assign m_tuser = res.status;

endmodule
